### hw/rtl/two_key_short_long_press_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-key press detector
// Concurrent assertion wrappers that compile to nothing when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TWO_KEY_SHORT_LONG_PRESS_DETECTOR_ASSERT_SVH
`define TWO_KEY_SHORT_LONG_PRESS_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TKSLPD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TKSLPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TKSLPD_ASSERT(lbl, clk, rst, prop, msg)
`define TKSLPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hw/rtl/tkslpd_pkg.sv
// ----------------------------------------------------------------------------
// Two-key press detector package
// Shared widths, event codes, register indexes, reset thresholds and the per-key status type.
// ----------------------------------------------------------------------------
package tkslpd_pkg;

  localparam int TICK_W    = 16;
  localparam int EVENT_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [EVENT_W-1:0] EV_NONE        = 3'd0;
  localparam logic [EVENT_W-1:0] EV_FUNC_SHORT  = 3'd1;
  localparam logic [EVENT_W-1:0] EV_POWER_LONG  = 3'd2;
  localparam logic [EVENT_W-1:0] EV_TIMER_SHORT = 3'd3;
  localparam logic [EVENT_W-1:0] EV_PAIR_LONG   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_LONG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_LONG  = 2'd2;

  localparam logic [TICK_W-1:0] SHORT_PRESS_RESET = 16'd10;
  localparam logic [TICK_W-1:0] POWER_LONG_RESET  = 16'd400;
  localparam logic [TICK_W-1:0] TIMER_LONG_RESET  = 16'd600;

  typedef struct packed {
    logic down_next;
    logic short_ev;
    logic long_ev;
  } key_status_t;

endpackage

### hw/rtl/tkslpd_if.sv
// ----------------------------------------------------------------------------
// Two-key press detector channels
// Valid/ready channels for the key poll and for the detector result.
// ----------------------------------------------------------------------------
interface tkslpd_poll_if;
  logic                          valid;
  logic                          ready;
  logic                          power_pin;
  logic                          timer_pin;
  logic [tkslpd_pkg::TICK_W-1:0] now_tick;

  modport source (output valid, power_pin, timer_pin, now_tick, input ready);
  modport sink   (input valid, power_pin, timer_pin, now_tick, output ready);
endinterface

interface tkslpd_result_if;
  logic                           valid;
  logic                           ready;
  logic [tkslpd_pkg::EVENT_W-1:0] key_event;
  logic                           power_held;
  logic                           timer_held;

  modport source (output valid, key_event, power_held, timer_held, input ready);
  modport sink   (input valid, key_event, power_held, timer_held, output ready);
endinterface

### hw/rtl/tkslpd_key.sv
// ----------------------------------------------------------------------------
// Single key tracker
// Holds the press state of one key and flags its short and long events.
// ----------------------------------------------------------------------------
`include "two_key_short_long_press_detector_assert.svh"

module tkslpd_key (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          pin,
  input  logic [tkslpd_pkg::TICK_W-1:0] now_tick,
  input  logic [tkslpd_pkg::TICK_W-1:0] short_ticks,
  input  logic [tkslpd_pkg::TICK_W-1:0] long_ticks,
  output tkslpd_pkg::key_status_t       status
);
  import tkslpd_pkg::*;

  logic              down;
  logic              short_seen;
  logic              long_seen;
  logic [TICK_W-1:0] start;

  logic              down_next;
  logic              short_seen_next;
  logic              long_seen_next;
  logic [TICK_W-1:0] start_next;
  logic [TICK_W-1:0] elapsed;
  logic              short_ev;
  logic              long_ev;

  always_comb begin
    elapsed         = now_tick - start;
    down_next       = down;
    short_seen_next = short_seen;
    long_seen_next  = long_seen;
    start_next      = start;
    short_ev        = 1'b0;
    long_ev         = 1'b0;
    if (pin) begin
      if (down) begin
        short_ev        = short_seen && !long_seen;
        down_next       = 1'b0;
        short_seen_next = 1'b0;
        long_seen_next  = 1'b0;
        start_next      = '0;
      end
    end else if (!down) begin
      down_next       = 1'b1;
      short_seen_next = 1'b0;
      long_seen_next  = 1'b0;
      start_next      = now_tick;
    end else if (!short_seen) begin
      if (elapsed > short_ticks) begin
        short_seen_next = 1'b1;
      end
    end else if (!long_seen) begin
      if (elapsed > long_ticks) begin
        long_seen_next = 1'b1;
        start_next     = '0;
        long_ev        = 1'b1;
      end
    end
  end

  assign status = '{down_next: down_next, short_ev: short_ev, long_ev: long_ev};

  always_ff @(posedge clk) begin
    if (rst) begin
      down       <= 1'b0;
      short_seen <= 1'b0;
      long_seen  <= 1'b0;
      start      <= '0;
    end else if (en) begin
      down       <= down_next;
      short_seen <= short_seen_next;
      long_seen  <= long_seen_next;
      start      <= start_next;
    end
  end

  // A long press is only ever reached through a short-qualified hold.
  `TKSLPD_ASSERT(a_long_needs_short, clk, rst, long_seen |-> (down && short_seen), "long flag without held short press")
  `TKSLPD_ASSERT(a_idle_clear, clk, rst, !down |-> (!short_seen && !long_seen && start == '0), "released key keeps stale state")
  `TKSLPD_ASSERT(a_long_latched, clk, rst, (en && long_ev) |=> (long_seen && start == '0), "long event not latched")

endmodule

### hw/rtl/two_key_short_long_press_detector.sv
// A result item appears in the cycle after its poll item is accepted.
// A poll item is taken every cycle while the result register is empty or being read;
// each key update is a 16-bit subtract and compare between the key state registers and the result register.
// Reset: synchronous rst clears both key states and the result valid flag and
// restores the thresholds to 10, 400 and 600 ticks.
// ----------------------------------------------------------------------------
// Two-key short/long press detector
// Tracks the power and timer keys and reports short and long press events.
// ----------------------------------------------------------------------------
`include "two_key_short_long_press_detector_assert.svh"

module two_key_short_long_press_detector (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tkslpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tkslpd_pkg::CFG_W-1:0]     cfg_data,
  tkslpd_poll_if.sink                      poll,
  tkslpd_result_if.source                  result
);
  import tkslpd_pkg::*;

  logic [TICK_W-1:0]  short_press_ticks;
  logic [TICK_W-1:0]  power_long_ticks;
  logic [TICK_W-1:0]  timer_long_ticks;

  logic               accept;
  logic               out_valid;
  logic [EVENT_W-1:0] key_event;
  logic               power_held;
  logic               timer_held;
  logic [EVENT_W-1:0] key_event_next;

  key_status_t        power_st;
  key_status_t        timer_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_press_ticks <= SHORT_PRESS_RESET;
      power_long_ticks  <= POWER_LONG_RESET;
      timer_long_ticks  <= TIMER_LONG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_PRESS: short_press_ticks <= cfg_data[TICK_W-1:0];
        REG_POWER_LONG:  power_long_ticks  <= cfg_data[TICK_W-1:0];
        REG_TIMER_LONG:  timer_long_ticks  <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign poll.ready = !out_valid || result.ready;
  assign accept     = poll.valid && poll.ready;

  tkslpd_key u_power (
    .clk         (clk),
    .rst         (rst),
    .en          (accept),
    .pin         (poll.power_pin),
    .now_tick    (poll.now_tick),
    .short_ticks (short_press_ticks),
    .long_ticks  (power_long_ticks),
    .status      (power_st)
  );

  tkslpd_key u_timer (
    .clk         (clk),
    .rst         (rst),
    .en          (accept),
    .pin         (poll.timer_pin),
    .now_tick    (poll.now_tick),
    .short_ticks (short_press_ticks),
    .long_ticks  (timer_long_ticks),
    .status      (timer_st)
  );

  // A timer long event wins, then a power long, a timer short and a power short.
  always_comb begin
    if (timer_st.long_ev) begin
      key_event_next = EV_PAIR_LONG;
    end else if (power_st.long_ev) begin
      key_event_next = EV_POWER_LONG;
    end else if (timer_st.short_ev) begin
      key_event_next = EV_TIMER_SHORT;
    end else if (power_st.short_ev) begin
      key_event_next = EV_FUNC_SHORT;
    end else begin
      key_event_next = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_event  <= key_event_next;
      power_held <= power_st.down_next;
      timer_held <= timer_st.down_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.key_event  = key_event;
  assign result.power_held = power_held;
  assign result.timer_held = timer_held;

  `TKSLPD_ASSERT(a_accept_fills, clk, rst, accept |=> out_valid, "accepted item produced no result")
  `TKSLPD_ASSERT(a_release_drops, clk, rst, (accept && poll.power_pin) |=> !power_held, "released power key still held")
  `TKSLPD_ASSERT(a_short_released, clk, rst, (out_valid && key_event == EV_FUNC_SHORT) |-> !power_held, "power short event while held")
  `TKSLPD_ASSERT(a_timer_short_released, clk, rst, (out_valid && key_event == EV_TIMER_SHORT) |-> !timer_held, "timer short event while held")

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-key press detector testbench
// Drives key polls through the valid/ready channels with random gaps and
// stalls, models both keys, and checks each result item against the model
// or a typed script row, over several thresholds, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
  import tkslpd_pkg::*;

  localparam int PWR         = 0;
  localparam int TMR         = 1;
  localparam int ROWS        = 25;
  localparam int PHASES      = 6;
  localparam int RANDOM_RUN  = 71;
  localparam int QUIET_LIMIT = 500;
  localparam int SHOW_LIMIT  = 40;

  typedef struct packed {
    logic              held;
    logic              short_ok;
    logic              long_done;
    logic [TICK_W-1:0] t0;
  } key_track_t;

  typedef struct packed {
    logic [EVENT_W-1:0] ev;
    logic               power;
    logic               timer;
  } press_result_t;

  typedef struct packed {
    logic          typed;
    press_result_t want;
  } poll_note_t;

  typedef struct packed {
    logic               pp;
    logic               tp;
    logic [TICK_W-1:0]  now;
    logic               typed;
    logic [EVENT_W-1:0] ev;
    logic               ph;
    logic               th;
  } poll_row_t;

  // Each typed row can be read straight off the key rules with the reset thresholds.
  poll_row_t script [ROWS] = '{
    '{1'b1, 1'b1, 16'd0,     1'b1, EV_NONE,        1'b0, 1'b0},
    '{1'b0, 1'b1, 16'd100,   1'b1, EV_NONE,        1'b1, 1'b0},
    '{1'b0, 1'b1, 16'd110,   1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b0, 1'b1, 16'd111,   1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b1, 1'b1, 16'd120,   1'b1, EV_FUNC_SHORT,  1'b0, 1'b0},
    '{1'b1, 1'b0, 16'd200,   1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b1, 1'b0, 16'd211,   1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b1, 1'b0, 16'd811,   1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b1, 1'b1, 16'd901,   1'b1, EV_NONE,        1'b0, 1'b0},
    '{1'b0, 1'b0, 16'd65530, 1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b0, 1'b0, 16'd5,     1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b0, 1'b0, 16'd395,   1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b0, 1'b0, 16'd65535, 1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b0, 1'b0, 16'd600,   1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b1, 1'b1, 16'd700,   1'b1, EV_NONE,        1'b0, 1'b0},
    '{1'b0, 1'b0, 16'd1000,  1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b0, 1'b0, 16'd1020,  1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b1, 1'b0, 16'd1700,  1'b1, EV_PAIR_LONG,   1'b0, 1'b1},
    '{1'b0, 1'b1, 16'd1800,  1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b0, 1'b0, 16'd1811,  1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b0, 1'b0, 16'd1830,  1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b1, 1'b1, 16'd1840,  1'b1, EV_TIMER_SHORT, 1'b0, 1'b0},
    '{1'b0, 1'b1, 16'd2000,  1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b0, 1'b1, 16'd3000,  1'b0, EV_NONE,        1'b0, 1'b0},
    '{1'b0, 1'b1, 16'd3001,  1'b0, EV_NONE,        1'b0, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  tkslpd_poll_if   poll_ch ();
  tkslpd_result_if result_ch ();

  two_key_short_long_press_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .poll      (poll_ch),
    .result    (result_ch)
  );

  key_track_t        keys [2] = '{default: '0};
  logic [TICK_W-1:0] short_limit;
  logic [TICK_W-1:0] long_limit [2];

  poll_note_t    typed_q [$];
  press_result_t due_results [$];
  int            mismatches   = 0;
  int            results_seen = 0;
  int            quiet        = 0;
  int            stall_left   = 0;
  bit            sink_steady  = 1'b0;
  bit            src_steady   = 1'b0;
  int            pwr_left     = 0;
  int            tmr_left     = 0;
  int            step_max;
  logic [TICK_W-1:0] tick_now;

  always #6 clk = ~clk;

  function automatic logic [EVENT_W-1:0] on_release(int k, logic pin,
                                                    logic [EVENT_W-1:0] code);
    logic [EVENT_W-1:0] ev;
    ev = EV_NONE;
    if (keys[k].held && pin) begin
      if (keys[k].short_ok && !keys[k].long_done) ev = code;
      keys[k] = '0;
    end
    return ev;
  endfunction

  function automatic logic [EVENT_W-1:0] on_hold(int k, logic pin, logic [TICK_W-1:0] now,
                                                 logic [EVENT_W-1:0] code);
    logic [EVENT_W-1:0] ev;
    logic [TICK_W-1:0]  span;
    ev = EV_NONE;
    if (!pin) begin
      if (!keys[k].held) begin
        keys[k]      = '0;
        keys[k].held = 1'b1;
        keys[k].t0   = now;
      end else begin
        span = now - keys[k].t0;
        if (!keys[k].short_ok) begin
          if (span > short_limit) keys[k].short_ok = 1'b1;
        end else if (!keys[k].long_done && span > long_limit[k]) begin
          keys[k].long_done = 1'b1;
          keys[k].t0        = '0;
          ev                = code;
        end
      end
    end
    return ev;
  endfunction

  function automatic press_result_t predict_poll(logic pp, logic tp, logic [TICK_W-1:0] now);
    press_result_t      r;
    logic [EVENT_W-1:0] e;
    r.ev = EV_NONE;
    e = on_release(PWR, pp, EV_FUNC_SHORT);
    if (e != EV_NONE) r.ev = e;
    e = on_release(TMR, tp, EV_TIMER_SHORT);
    if (e != EV_NONE) r.ev = e;
    e = on_hold(PWR, pp, now, EV_POWER_LONG);
    if (e != EV_NONE) r.ev = e;
    e = on_hold(TMR, tp, now, EV_PAIR_LONG);
    if (e != EV_NONE) r.ev = e;
    r.power = keys[PWR].held;
    r.timer = keys[TMR].held;
    return r;
  endfunction

  function automatic int pause_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int tick_stride(logic [TICK_W-1:0] s, logic [TICK_W-1:0] p,
                                     logic [TICK_W-1:0] t);
    int n;
    n = (int'(p) + int'(t)) / 8 + int'(s) / 2 + 2;
    return (n > 16384) ? 16384 : n;
  endfunction

  function automatic logic next_pin(inout int left);
    if (left == 0 && $urandom_range(0, 2) == 0) left = $urandom_range(1, 14);
    if (left == 0) return 1'b1;
    left--;
    return 1'b0;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < SHOW_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_poll(logic pp, logic tp, logic [TICK_W-1:0] now, logic typed,
                           press_result_t want);
    int gap;
    gap = (src_steady || $urandom_range(0, 1) == 0) ? 0 : pause_len();
    if ($urandom_range(0, 31) == 0) src_steady = !src_steady;
    if (gap != 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_ch.valid     <= 1'b1;
    poll_ch.power_pin <= pp;
    poll_ch.timer_pin <= tp;
    poll_ch.now_tick  <= now;
    typed_q.push_back('{typed, want});
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
  endtask

  task automatic shape_poll(output logic pp, output logic tp, output logic [TICK_W-1:0] now);
    if ($urandom_range(0, 7) == 0) begin
      pp       = 1'($urandom_range(0, 1));
      tp       = 1'($urandom_range(0, 1));
      tick_now = TICK_W'($urandom_range(0, 65535));
    end else begin
      pp = next_pin(pwr_left);
      tp = next_pin(tmr_left);
      if ($urandom_range(0, 3) == 0) tick_now += TICK_W'($urandom_range(0, 3));
      else tick_now += TICK_W'($urandom_range(0, step_max));
    end
    now = tick_now;
  endtask

  task automatic hold_until_drained();
    poll_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_limits(logic [TICK_W-1:0] s, logic [TICK_W-1:0] p,
                              logic [TICK_W-1:0] t);
    write_reg(REG_SHORT_PRESS, s);
    write_reg(REG_POWER_LONG, p);
    write_reg(REG_TIMER_LONG, t);
    cfg_we <= 1'b0;
    short_limit    = s;
    long_limit[PWR] = p;
    long_limit[TMR] = t;
    step_max       = tick_stride(s, p, t);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else begin
      result_ch.ready <= 1'b1;
      if (!sink_steady && $urandom_range(0, 3) == 0) stall_left <= pause_len();
    end
    if ($urandom_range(0, 63) == 0) sink_steady <= !sink_steady;
  end

  always @(posedge clk) begin : watch_results
    press_result_t got;
    press_result_t want;
    poll_note_t    note;
    if (!rst && poll_ch.valid && poll_ch.ready) begin
      want = predict_poll(poll_ch.power_pin, poll_ch.timer_pin, poll_ch.now_tick);
      note = typed_q.pop_front();
      if (note.typed) want = note.want;
      due_results.push_back(want);
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = '{result_ch.key_event, result_ch.power_held, result_ch.timer_held};
      results_seen++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result item %0d arrived with none expected", results_seen));
      end else begin
        want = due_results.pop_front();
        if (got.ev !== want.ev)
          report_mismatch($sformatf("item %0d key_event %0d, expected %0d",
                                    results_seen, got.ev, want.ev));
        if (got.power !== want.power)
          report_mismatch($sformatf("item %0d power_held %0b, expected %0b",
                                    results_seen, got.power, want.power));
        if (got.timer !== want.timer)
          report_mismatch($sformatf("item %0d timer_held %0b, expected %0b",
                                    results_seen, got.timer, want.timer));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready) ||
        cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("two_key_short_long_press_detector verification failed");
        $finish;
      end
    end
  end

  initial begin
    press_result_t     want;
    logic              pp;
    logic              tp;
    logic [TICK_W-1:0] now;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_SHORT_PRESS;
    cfg_data          <= '0;
    poll_ch.valid     <= 1'b0;
    poll_ch.power_pin <= 1'b1;
    poll_ch.timer_pin <= 1'b1;
    poll_ch.now_tick  <= '0;
    short_limit       = SHORT_PRESS_RESET;
    long_limit[PWR]   = POWER_LONG_RESET;
    long_limit[TMR]   = TIMER_LONG_RESET;
    step_max          = tick_stride(SHORT_PRESS_RESET, POWER_LONG_RESET, TIMER_LONG_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      want = '{script[i].ev, script[i].ph, script[i].th};
      send_poll(script[i].pp, script[i].tp, script[i].now, script[i].typed, want);
    end
    tick_now = script[ROWS-1].now;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        hold_until_drained();
        case (ph)
          1: apply_limits(16'd0, 16'd0, 16'hffff);
          2: apply_limits(16'hffff, 16'd0, 16'd0);
          3: apply_limits(16'd3, 16'd40, 16'd25);
          4: apply_limits(TICK_W'($urandom_range(0, 40)), TICK_W'($urandom_range(0, 600)),
                          TICK_W'($urandom_range(0, 600)));
          default: apply_limits(TICK_W'($urandom_range(0, 65535)),
                                TICK_W'($urandom_range(0, 65535)),
                                TICK_W'($urandom_range(0, 65535)));
        endcase
      end
      for (int n = 0; n < RANDOM_RUN; n++) begin
        shape_poll(pp, tp, now);
        send_poll(pp, tp, now, 1'b0, '0);
      end
    end

    hold_until_drained();
    repeat (4) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d result items never arrived", due_results.size()));
    if (mismatches == 0) begin
      $display("two_key_short_long_press_detector verification clean");
    end else begin
      $display("two_key_short_long_press_detector verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/tkslpd_pkg.sv
hw/rtl/tkslpd_if.sv
hw/rtl/tkslpd_key.sv
hw/rtl/two_key_short_long_press_detector.sv
bench/testbench.sv
